// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the modular exponentiation block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising edge of a clock, off while reset is low.
`define MEXP_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same check on the block's own clock and reset.
`define MEXP_ASSERT(lbl, prop, msg) \
  `MEXP_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- hdl/mexp_pkg.sv -----
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Widths, reset values, register indexes and shared types.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int MOD_BITS  = 32;
  localparam int DATA_BITS = 32;
  localparam int EXP_BITS  = 32;
  localparam int CNT_BITS  = $clog2(DATA_BITS);

  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DATA_BITS - 1);
  localparam logic [MOD_BITS-1:0] MOD_ONE  = MOD_BITS'(1);

  localparam logic [EXP_BITS-1:0]  EXPONENT_RESET = EXP_BITS'(65537);
  localparam logic [DATA_BITS-1:0] MODULUS_RESET  = DATA_BITS'(2);

  typedef enum logic {
    CFG_EXPONENT = 1'b0,
    CFG_MODULUS  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [EXP_BITS-1:0]  exponent;
    logic [DATA_BITS-1:0] modulus;
  } cfg_t;

endpackage

// ----- hdl/mexp_addmod.sv -----
// ----------------------------------------------------------------------------
// Modular adder
// Computes (a + b + cin) mod m for a + b + cin below twice m.
// ----------------------------------------------------------------------------
module mexp_addmod (
  input  logic [mexp_pkg::MOD_BITS-1:0] a_i,
  input  logic [mexp_pkg::MOD_BITS-1:0] b_i,
  input  logic                          cin_i,
  input  logic [mexp_pkg::MOD_BITS-1:0] m_i,
  output logic [mexp_pkg::MOD_BITS-1:0] sum_o
);
  import mexp_pkg::*;

  logic [MOD_BITS:0] raw;
  logic [MOD_BITS:0] red;

  assign raw = {1'b0, a_i} + {1'b0, b_i} + {{MOD_BITS{1'b0}}, cin_i};
  assign red = raw - {1'b0, m_i};

  always_comb begin
    if (raw >= {1'b0, m_i}) begin
      sum_o = red[MOD_BITS-1:0];
    end else begin
      sum_o = raw[MOD_BITS-1:0];
    end
  end

endmodule

// ----- hdl/mexp_engine.sv -----
// ----------------------------------------------------------------------------
// Exponentiation engine
// Sequencer around one modular adder: input reduction, shift-add multiply
// and right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mexp_engine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mexp_pkg::cfg_t                 cfg_i,
  input  logic                           start_i,
  input  logic [mexp_pkg::DATA_BITS-1:0] value_i,
  output logic                           busy_o,
  output logic                           valid_o,
  output logic [mexp_pkg::DATA_BITS-1:0] result_o
);
  import mexp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_POW_MUL,
    ST_POW_SQR,
    ST_MUL_ADD,
    ST_MUL_DBL
  } state_e;

  state_e                state_q;
  state_e                ret_q;
  logic                  tgt_acc_q;
  logic [MOD_BITS-1:0]   m_q;
  logic [EXP_BITS-1:0]   e_q;
  logic [DATA_BITS-1:0]  v_q;
  logic [CNT_BITS-1:0]   cnt_q;
  logic [MOD_BITS-1:0]   acc_q;
  logic [MOD_BITS-1:0]   base_q;
  logic [MOD_BITS-1:0]   x_q;
  logic [MOD_BITS-1:0]   y_q;
  logic [MOD_BITS-1:0]   p_q;
  logic                  valid_q;
  logic [DATA_BITS-1:0]  res_q;

  logic [63:0]           mod_wide;
  logic [63:0]           acc_wide;
  logic [MOD_BITS-1:0]   m_in;
  logic [DATA_BITS-1:0]  acc_res;
  logic [MOD_BITS-1:0]   ua;
  logic [MOD_BITS-1:0]   ub;
  logic                  ucin;
  logic [MOD_BITS-1:0]   sum;

  assign mod_wide = 64'(cfg_i.modulus);
  assign m_in     = mod_wide[MOD_BITS-1:0];
  assign acc_wide = 64'(acc_q);
  assign acc_res  = acc_wide[DATA_BITS-1:0];

  always_comb begin
    ua   = x_q;
    ub   = x_q;
    ucin = 1'b0;
    case (state_q)
      ST_REDUCE: begin
        ua   = base_q;
        ub   = base_q;
        ucin = v_q[DATA_BITS-1];
      end
      ST_MUL_ADD: begin
        if (y_q[0]) begin
          ua = p_q;
        end
      end
      default: begin
        ua = x_q;
      end
    endcase
  end

  mexp_addmod u_addmod (
    .a_i   (ua),
    .b_i   (ub),
    .cin_i (ucin),
    .m_i   (m_q),
    .sum_o (sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ret_q     <= ST_POW_MUL;
      tgt_acc_q <= 1'b0;
      m_q       <= '0;
      e_q       <= '0;
      v_q       <= '0;
      cnt_q     <= '0;
      acc_q     <= '0;
      base_q    <= '0;
      x_q       <= '0;
      y_q       <= '0;
      p_q       <= '0;
      valid_q   <= 1'b0;
      res_q     <= '0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            m_q    <= m_in;
            e_q    <= cfg_i.exponent;
            v_q    <= value_i;
            base_q <= '0;
            cnt_q  <= '0;
            acc_q  <= (m_in == MOD_ONE) ? '0 : MOD_ONE;
            if (m_in == '0) begin
              valid_q <= 1'b1;
              res_q   <= '0;
            end else begin
              state_q <= ST_REDUCE;
            end
          end
        end
        ST_REDUCE: begin
          base_q <= sum;
          v_q    <= v_q << 1;
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == CNT_LAST) begin
            state_q <= ST_POW_MUL;
          end
        end
        ST_POW_MUL: begin
          if (e_q == '0) begin
            valid_q <= 1'b1;
            res_q   <= acc_res;
            state_q <= ST_IDLE;
          end else if (e_q[0]) begin
            x_q       <= acc_q;
            y_q       <= base_q;
            p_q       <= '0;
            tgt_acc_q <= 1'b1;
            ret_q     <= ST_POW_SQR;
            state_q   <= ST_MUL_ADD;
          end else begin
            state_q <= ST_POW_SQR;
          end
        end
        ST_POW_SQR: begin
          e_q <= e_q >> 1;
          if (e_q[EXP_BITS-1:1] == '0) begin
            valid_q <= 1'b1;
            res_q   <= acc_res;
            state_q <= ST_IDLE;
          end else begin
            x_q       <= base_q;
            y_q       <= base_q;
            p_q       <= '0;
            tgt_acc_q <= 1'b0;
            ret_q     <= ST_POW_MUL;
            state_q   <= ST_MUL_ADD;
          end
        end
        ST_MUL_ADD: begin
          if (y_q == '0) begin
            if (tgt_acc_q) begin
              acc_q <= p_q;
            end else begin
              base_q <= p_q;
            end
            state_q <= ret_q;
          end else if (y_q[0]) begin
            p_q     <= sum;
            state_q <= ST_MUL_DBL;
          end else begin
            x_q <= sum;
            y_q <= y_q >> 1;
          end
        end
        ST_MUL_DBL: begin
          x_q     <= sum;
          y_q     <= y_q >> 1;
          state_q <= ST_MUL_ADD;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign valid_o  = valid_q;
  assign result_o = res_q;

  `MEXP_ASSERT(a_valid_idle, valid_q |-> (state_q == ST_IDLE), "result shown while busy")
  `MEXP_ASSERT(a_start_acts, (start_i && state_q == ST_IDLE) |=> (busy_o || valid_q), "item dropped")
  `MEXP_ASSERT(a_mul_range, (state_q == ST_MUL_ADD) |-> (x_q < m_q && p_q < m_q), "operand not reduced")

endmodule

// ----- hdl/modular_exponentiation.sv -----
// Sequence: the input is first reduced modulo the modulus, then each exponent bit passes
// through the ST_POW_MUL and ST_POW_SQR states and up to two shift-add multiplies;
// one item at a time (busy high).
// All of the arithmetic goes through the single modular adder.
// The result strobe is high for one cycle; the receiver cannot stall it.
// Reset: asynchronous, active low; exponent returns to 65537 and modulus to 2.
// ----------------------------------------------------------------------------
// Modular exponentiation top level
// Configuration registers and the exponentiation engine.
// ----------------------------------------------------------------------------
module modular_exponentiation (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  mexp_pkg::cfg_idx_e             cfg_idx_i,
  input  logic [mexp_pkg::DATA_BITS-1:0] cfg_data_i,
  input  logic                           start,
  output logic                           busy,
  input  logic [mexp_pkg::DATA_BITS-1:0] value_i,
  output logic                           result_valid_o,
  output logic [mexp_pkg::DATA_BITS-1:0] result_o
);
  import mexp_pkg::*;

  logic [EXP_BITS-1:0]  exponent_q;
  logic [DATA_BITS-1:0] modulus_q;
  cfg_t                 cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exponent_q <= EXPONENT_RESET;
      modulus_q  <= MODULUS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_EXPONENT: exponent_q <= cfg_data_i;
        CFG_MODULUS:  modulus_q  <= cfg_data_i;
        default: begin
          exponent_q <= exponent_q;
        end
      endcase
    end
  end

  assign cfg.exponent = exponent_q;
  assign cfg.modulus  = modulus_q;

  mexp_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .start_i  (start),
    .value_i  (value_i),
    .busy_o   (busy),
    .valid_o  (result_valid_o),
    .result_o (result_o)
  );

endmodule
